### src/grh_pkg.sv
package grh_pkg;

	// Geometry: one cell is CELL_SIZE pixels, positions carry 8 fraction bits
	localparam int CELL_SIZE   = 64;
	localparam int MAP_DIM     = 64;
	localparam int FRAC_BITS   = 8;
	localparam int CELL_SHIFT  = $clog2(CELL_SIZE) + FRAC_BITS;
	localparam int MAP_BITS    = $clog2(MAP_DIM);
	localparam int RAM_AW      = 2 * MAP_BITS;
	localparam int RAM_DEPTH   = MAP_DIM * MAP_DIM;
	localparam int X_BOUND_OFS = 6;
	localparam int IT_FRAC     = 12;

	// Field widths
	localparam int PX_W    = 20;
	localparam int IT_W    = 24;
	localparam int LIM_W   = 7;
	localparam int OUT_W   = 22;
	localparam int CELL_W  = 6;
	localparam int CODE_W  = 2;
	localparam int CFG_IW  = 2;

	// Internal datapath widths
	localparam int DY_W   = CELL_SHIFT + 2;
	localparam int PROD_W = DY_W + IT_W;
	localparam int X_W    = PROD_W - IT_FRAC + 1;
	localparam int XS_W   = IT_W + CELL_SHIFT - IT_FRAC + 1;
	localparam int Y_W    = ((PX_W + 1 > CELL_SHIFT + 8) ? PX_W + 1 : CELL_SHIFT + 8) + 1;
	localparam int IDX_W  = LIM_W + 2;

	localparam logic [IDX_W-1:0] MAP_DIM_I = IDX_W'(MAP_DIM);

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_X_LIMIT = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_Y_LIMIT = 2'd1;
	localparam logic [LIM_W-1:0]  LIMIT_RST   = 7'd64;

	typedef enum logic [CODE_W-1:0] {
		CODE_OPEN      = 2'd0,
		CODE_WALL      = 2'd1,
		CODE_DOOR_SHUT = 2'd2,
		CODE_DOOR_OPEN = 2'd3
	} cell_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_INIT,
		ST_WALK,
		ST_FIN
	} grh_state_t;

	// Sequencer commands to the walker
	typedef struct packed {
		logic capture;
		logic mul;
		logic init;
		logic step;
	} walk_ctl_t;

	// Walker status back to the sequencer
	typedef struct packed {
		logic cand_off;
		logic cell_out;
	} walk_sts_t;

	// Clamp to the signed output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [X_W-1:0] v);
		logic signed [X_W-1:0] hi;
		logic signed [X_W-1:0] lo;
		hi = X_W'((2 ** (OUT_W - 1)) - 1);
		lo = -X_W'(2 ** (OUT_W - 1));
		if (v > hi) begin
			sat_out = hi[OUT_W-1:0];
		end else if (v < lo) begin
			sat_out = lo[OUT_W-1:0];
		end else begin
			sat_out = v[OUT_W-1:0];
		end
	endfunction

endpackage

### src/grh_ram.sv
module grh_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/grh_walker.sv
module grh_walker import grh_pkg::*; (
	input  logic                     clk,
	input  walk_ctl_t                ctl,
	input  logic [PX_W-1:0]          player_x,
	input  logic [PX_W-1:0]          player_y,
	input  logic signed [IT_W-1:0]   inv_tan,
	input  logic                     ray_up,
	input  logic                     dir_down,
	input  logic                     dir_left,
	input  logic                     dir_right,
	input  logic [LIM_W-1:0]         x_limit,
	input  logic [LIM_W-1:0]         y_limit,
	output walk_sts_t                sts,
	output logic [RAM_AW-1:0]        rd_addr,
	output logic signed [OUT_W-1:0]  res_x,
	output logic signed [OUT_W-1:0]  res_y
);

	localparam logic signed [Y_W-1:0] CQ_Y = Y_W'(2 ** CELL_SHIFT);
	localparam logic signed [Y_W-1:0] PIX_Y = Y_W'(2 ** FRAC_BITS);

	logic [PX_W-1:0]          px_q;
	logic [PX_W-1:0]          py_q;
	logic signed [IT_W-1:0]   it_q;
	logic                     up_q;
	logic                     down_q;
	logic                     left_q;
	logic                     right_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [XS_W-1:0]   xs_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [Y_W-1:0]    y_q;
	logic                     cell_out_q;

	logic [Y_W-1:0]                   py_ext;
	logic signed [Y_W-1:0]            y0_c;
	logic signed [DY_W-1:0]           dy_c;
	logic signed [PROD_W-1:0]         prod_c;
	logic signed [IT_W+CELL_SHIFT-1:0] xs_wide;
	logic signed [XS_W-1:0]           xs_raw;
	logic signed [XS_W-1:0]           xs_l;
	logic signed [XS_W-1:0]           xs_c;
	logic signed [Y_W-1:0]            ys_c;
	logic signed [X_W-1:0]            add_a;
	logic signed [X_W-1:0]            add_b;
	logic signed [X_W-1:0]            cand_x;
	logic signed [Y_W-1:0]            cand_y;
	logic signed [Y_W-1:0]            yl_c;
	logic signed [LIM_W:0]            xd_c;
	logic signed [X_W-1:0]            xb_c;
	logic signed [Y_W-1:0]            yb_c;
	logic [IDX_W-1:0]                 col_c;
	logic [IDX_W-1:0]                 row_c;

	// First crossing row and vertical offset from the origin
	always_comb begin
		py_ext = Y_W'(py_q);
		y0_c   = $signed({py_ext[Y_W-1:CELL_SHIFT], {CELL_SHIFT{1'b0}}})
			+ (down_q ? CQ_Y : '0);
		dy_c   = DY_W'(y0_c - $signed(py_ext));
		prod_c = dy_c * it_q;
	end

	// Horizontal step per row, sign fixed by the direction flags
	always_comb begin
		xs_wide = $signed({it_q, {CELL_SHIFT{1'b0}}});
		xs_raw  = XS_W'(xs_wide >>> IT_FRAC);
		xs_l    = (left_q && xs_raw > 0) ? -xs_raw : xs_raw;
		xs_c    = (right_q && xs_l < 0) ? -xs_l : xs_l;
		ys_c    = up_q ? -CQ_Y : CQ_Y;
	end

	// Shared position adder: first crossing on init, one step otherwise
	always_comb begin
		add_a  = ctl.init ? X_W'($signed({1'b0, px_q})) : x_q;
		add_b  = ctl.init ? X_W'(prod_q >>> IT_FRAC) : X_W'(xs_q);
		cand_x = add_a + add_b;
		cand_y = ctl.init ? y_q : y_q + ys_c;
	end

	// Bounds and cell lookup for the candidate point
	always_comb begin
		xd_c = $signed({1'b0, x_limit}) - $signed((LIM_W + 1)'(X_BOUND_OFS));
		xb_c = X_W'(xd_c) <<< CELL_SHIFT;
		yb_c = $signed(Y_W'({y_limit, {CELL_SHIFT{1'b0}}}));
		sts.cand_off = !(cand_x >= 0 && cand_x <= xb_c && cand_y >= 0 && cand_y <= yb_c);
		sts.cell_out = cell_out_q;
		yl_c  = up_q ? cand_y - PIX_Y : cand_y;
		col_c = cand_x[CELL_SHIFT+IDX_W-1:CELL_SHIFT];
		row_c = yl_c[Y_W-1] ? '0 : yl_c[CELL_SHIFT+IDX_W-1:CELL_SHIFT];
		rd_addr = {col_c[MAP_BITS-1:0], row_c[MAP_BITS-1:0]};
	end

	// Item capture and walk registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			px_q    <= player_x;
			py_q    <= player_y;
			it_q    <= inv_tan;
			up_q    <= ray_up;
			down_q  <= dir_down;
			left_q  <= dir_left;
			right_q <= dir_right;
		end
		if (ctl.mul) begin
			prod_q <= prod_c;
			xs_q   <= xs_c;
			y_q    <= y0_c;
		end
		if (ctl.init || ctl.step) begin
			x_q        <= cand_x;
			y_q        <= cand_y;
			cell_out_q <= (col_c >= MAP_DIM_I) || (row_c >= MAP_DIM_I);
		end
	end

	assign res_x = sat_out(x_q);
	assign res_y = sat_out(X_W'(y_q));

endmodule

### src/grid_ray_horizontal_hit_top.sv
// Horizontal-crossing ray caster over a 64 x 64 map of 2-bit cells. An item with
// op 0 writes one cell code; an item with op 1 casts a ray from the player
// position and reports where it meets the first wall or closed door on a
// horizontal grid line, or where it leaves the x/y limits. Every item gives one
// result; a write gives all zeros. A write goes from idle to the finish state; a
// cast goes through the multiply, init and walk states before finish, which
// loads the result into the output register once that register is free. Up to
// 65 cells are examined with the default limits: the walk reads one cell per
// cycle from the single read port of the map RAM, using one shared position
// adder. The block takes no new item during a cast or write, but it accepts
// the next item while a finished result still waits in the output register.
// The map contents are undefined after reset until written; there is no
// clearing pass.
module grid_ray_horizontal_hit_top import grh_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic [CODE_W-1:0]       cell_code,
	input  logic [PX_W-1:0]         player_x,
	input  logic [PX_W-1:0]         player_y,
	input  logic signed [IT_W-1:0]  inv_tan,
	input  logic                    ray_up,
	input  logic                    dir_down,
	input  logic                    dir_left,
	input  logic                    dir_right,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] hit_x,
	output logic signed [OUT_W-1:0] hit_y,
	output logic                    door_flag,
	output logic                    left_map,
	input  logic                    cfg_we,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [LIM_W-1:0]        cfg_data
);

	grh_state_t state_q, state_d;
	logic       door_q, door_d;
	logic       off_q, off_d;
	logic       zero_q, zero_d;
	logic       out_valid_q;
	logic       load_out;
	logic       ram_we;
	logic       accept;
	logic       out_free;
	logic       wr_ok;

	logic [LIM_W-1:0]        x_limit_q;
	logic [LIM_W-1:0]        y_limit_q;
	logic signed [OUT_W-1:0] hit_x_q;
	logic signed [OUT_W-1:0] hit_y_q;
	logic                    door_out_q;
	logic                    left_out_q;

	walk_ctl_t               ctl;
	walk_sts_t               sts;
	logic [RAM_AW-1:0]       rd_addr;
	logic [RAM_AW-1:0]       wr_addr;
	logic [CODE_W-1:0]       rd_data;
	logic [IDX_W-1:0]        cx_e;
	logic [IDX_W-1:0]        cy_e;
	logic signed [OUT_W-1:0] res_x;
	logic signed [OUT_W-1:0] res_y;
	cell_code_t              code;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q <= LIMIT_RST;
			y_limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_X_LIMIT) begin
				x_limit_q <= cfg_data;
			end
			if (cfg_index == CFG_Y_LIMIT) begin
				y_limit_q <= cfg_data;
			end
		end
	end

	// Map write address; cells beyond the store are dropped
	always_comb begin
		cx_e    = IDX_W'(cell_x);
		cy_e    = IDX_W'(cell_y);
		wr_ok   = (cx_e < MAP_DIM_I) && (cy_e < MAP_DIM_I);
		wr_addr = {cx_e[MAP_BITS-1:0], cy_e[MAP_BITS-1:0]};
	end

	grh_ram #(
		.WIDTH(CODE_W),
		.DEPTH(RAM_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(cell_code),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	grh_walker u_walk (
		.clk      (clk),
		.ctl      (ctl),
		.player_x (player_x),
		.player_y (player_y),
		.inv_tan  (inv_tan),
		.ray_up   (ray_up),
		.dir_down (dir_down),
		.dir_left (dir_left),
		.dir_right(dir_right),
		.x_limit  (x_limit_q),
		.y_limit  (y_limit_q),
		.sts      (sts),
		.rd_addr  (rd_addr),
		.res_x    (res_x),
		.res_y    (res_y)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	// Cells beyond the store read as wall
	assign code     = sts.cell_out ? CODE_WALL : cell_code_t'(rd_data);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			door_q  <= 1'b0;
			off_q   <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			door_q  <= door_d;
			off_q   <= off_d;
			zero_q  <= zero_d;
		end
	end

	// Sequencer next state and commands
	always_comb begin
		state_d  = state_q;
		door_d   = door_q;
		off_d    = off_q;
		zero_d   = zero_q;
		ctl      = '0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.capture = 1'b1;
					door_d      = 1'b0;
					off_d       = 1'b0;
					if (op == OP_WRITE) begin
						ram_we  = wr_ok;
						zero_d  = 1'b1;
						state_d = ST_FIN;
					end else begin
						zero_d  = 1'b0;
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_INIT;
			end
			ST_INIT: begin
				ctl.init = 1'b1;
				if (sts.cand_off) begin
					off_d   = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				door_d = code inside {CODE_DOOR_SHUT, CODE_DOOR_OPEN};
				if (code == CODE_WALL || code == CODE_DOOR_SHUT) begin
					state_d = ST_FIN;
				end else begin
					ctl.step = 1'b1;
					if (sts.cand_off) begin
						off_d   = 1'b1;
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_x_q    <= zero_q ? '0 : res_x;
			hit_y_q    <= zero_q ? '0 : res_y;
			door_out_q <= zero_q ? 1'b0 : door_q;
			left_out_q <= zero_q ? 1'b0 : off_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_x     = hit_x_q;
	assign hit_y     = hit_y_q;
	assign door_flag = door_out_q;
	assign left_map  = left_out_q;

endmodule

### src/grh_checker.sv
module grh_checker import grh_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] hit_x,
	input logic signed [OUT_W-1:0] hit_y,
	input logic                    door_flag,
	input logic                    left_map
);

	// One item at a time: input closes right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after an item was accepted");

	// A new result is posted only as the sequencer returns to idle
	a_result_with_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result posted while the block was still busy");

	// A result never appears while the block is still busy with an item
	a_no_result_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !in_ready) |=> !(out_valid && !in_ready))
		else $error("result appeared while an item was still in work");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(hit_x) && $stable(hit_y)
			&& $stable(door_flag) && $stable(left_map)))
		else $error("stalled result changed");

endmodule

bind grid_ray_horizontal_hit_top grh_checker u_grh_checker (.*);
